FILE: rtl/assert_macros.svh
// Assertion macros for the RTL; included by the top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dps_pkg.sv
// Types, constants and helper functions for the DHCP packet segmenter.
// No dependencies; imported by every module of the block.
package dps_pkg;

    localparam int MAX_PACKET_BYTES = 4096;
    localparam int CHADDR_BYTES     = 16;
    localparam int SNAME_BYTES      = 64;
    localparam int FILE_BYTES       = 128;

    localparam int HDR_FIELDS    = 15;
    localparam int POS_W         = $clog2(MAX_PACKET_BYTES + 1);
    localparam int WIDE_W        = (POS_W + 1 > 13) ? POS_W + 1 : 13;
    localparam int SEG_W         = 12;
    localparam int FIDX_W        = 4;
    localparam int LEFT_W        = 8;
    localparam logic [SEG_W-1:0] SAT12 = 12'hFFF;
    localparam logic [7:0] END_CODE      = 8'hFF;
    localparam logic [7:0] PAD_CODE      = 8'h00;
    localparam int OPT_HDR_BYTES = 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        KIND_HDR = 3'd0,
        KIND_PAD = 3'd1,
        KIND_END = 3'd2,
        KIND_OPT = 3'd3,
        KIND_BAD = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_CODE = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [FIDX_W-1:0]  field_index;
        logic [7:0]         option_code;
        logic [SEG_W-1:0]   offset;
        logic [SEG_W-1:0]   length;
    } t_rec;

    // one byte's worth of results: one or two records
    typedef struct packed {
        logic two;
        t_rec r0;
        t_rec r1;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [LEFT_W-1:0] hdr_size(input logic [FIDX_W-1:0] idx);
        logic [LEFT_W-1:0] sz;
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd3:         sz = 8'd1;
            4'd4, 4'd7, 4'd8, 4'd9, 4'd10:  sz = 8'd4;
            4'd5, 4'd6:                     sz = 8'd2;
            4'd11:                          sz = LEFT_W'(CHADDR_BYTES);
            4'd12:                          sz = LEFT_W'(SNAME_BYTES);
            4'd13:                          sz = LEFT_W'(FILE_BYTES);
            4'd14:                          sz = 8'd4;
            default:                        sz = '0;
        endcase
        return sz;
    endfunction

    function automatic logic [SEG_W-1:0] sat12(input logic [WIDE_W-1:0] v);
        return (v > WIDE_W'(SAT12)) ? SAT12 : v[SEG_W-1:0];
    endfunction

    function automatic t_rec mk_rec(input t_kind kind, input logic [FIDX_W-1:0] fidx,
                                    input logic [7:0] code, input logic [WIDE_W-1:0] off,
                                    input logic [WIDE_W-1:0] len);
        t_rec r;
        r.kind        = kind;
        r.field_index = fidx;
        r.option_code = code;
        r.offset      = sat12(off);
        r.length      = sat12(len);
        return r;
    endfunction

endpackage

FILE: rtl/dps_front.sv
// Front end: accepts packet bytes, tracks header/option parsing state and
// builds the one or two segment records each byte causes. Uses dps_pkg.
module dps_front import dps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  t_qstat      i_qstat,
    output t_push       o_push
);

    logic [FIDX_W-1:0]  r_hf,        n_hf;
    logic [POS_W-1:0]   r_pos,       n_pos;
    logic [POS_W-1:0]   r_start,     n_start;
    logic [LEFT_W-1:0]  r_left,      n_left;
    t_phase             r_phase,     n_phase;
    logic [7:0]         r_held,      n_held;
    logic [POS_W-1:0]   r_pad_start, n_pad_start;
    logic [SEG_W-1:0]   r_pad_cnt,   n_pad_cnt;
    logic               r_ovf,       n_ovf;

    t_rec               recs [2];
    logic [1:0]         nrec;
    logic               accept;

    logic [WIDE_W-1:0]  pos_w;
    logic [WIDE_W-1:0]  start_w;
    logic [WIDE_W-1:0]  start_eff;
    logic [LEFT_W-1:0]  left_eff;
    logic [LEFT_W-1:0]  left_dec;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_hf        = r_hf;
        n_pos       = r_pos;
        n_start     = r_start;
        n_left      = r_left;
        n_phase     = r_phase;
        n_held      = r_held;
        n_pad_start = r_pad_start;
        n_pad_cnt   = r_pad_cnt;
        n_ovf       = r_ovf;
        recs[0]     = '0;
        recs[1]     = '0;
        nrec        = '0;
        pos_w       = WIDE_W'(r_pos);
        start_w     = WIDE_W'(r_start);
        start_eff   = start_w;
        left_eff    = r_left;
        left_dec    = '0;

        if (r_ovf) begin
            // past capacity: swallow bytes until the last one
        end else if (r_pos >= POS_W'(MAX_PACKET_BYTES)) begin
            if (r_hf < FIDX_W'(HDR_FIELDS)) begin
                if (r_left != '0)
                    recs[0] = mk_rec(KIND_BAD, '0, '0, start_w, pos_w - start_w);
                else
                    recs[0] = mk_rec(KIND_BAD, '0, '0, pos_w, '0);
                nrec = 2'd1;
            end else if (r_phase == PH_CODE) begin
                if (r_pad_cnt != '0) begin
                    recs[nrec[0]] = mk_rec(KIND_PAD, '0, '0, WIDE_W'(r_pad_start),
                                           WIDE_W'(r_pad_cnt));
                    nrec = nrec + 2'd1;
                    n_pad_cnt   = '0;
                    n_pad_start = '0;
                end
                recs[nrec[0]] = mk_rec(KIND_BAD, '0, '0, pos_w, '0);
                nrec = nrec + 2'd1;
            end else begin
                recs[0] = mk_rec(KIND_BAD, '0, '0, start_w, pos_w - start_w);
                nrec = 2'd1;
            end
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + 1'b1;
            if (r_hf < FIDX_W'(HDR_FIELDS)) begin
                if (r_left == '0) begin
                    start_eff = pos_w;
                    left_eff  = hdr_size(r_hf);
                    n_start   = r_pos;
                end
                left_dec = left_eff - 1'b1;
                n_left   = left_dec;
                if (left_dec == '0) begin
                    recs[nrec[0]] = mk_rec(KIND_HDR, r_hf, '0, start_eff,
                                           WIDE_W'(hdr_size(r_hf)));
                    nrec = nrec + 2'd1;
                    n_hf = r_hf + 1'b1;
                    // a zero-length remainder unless the cookie just completed
                    if (i_last_byte && r_hf < FIDX_W'(HDR_FIELDS - 1)) begin
                        recs[nrec[0]] = mk_rec(KIND_BAD, '0, '0, pos_w + 1'b1, '0);
                        nrec = nrec + 2'd1;
                    end
                end else if (i_last_byte) begin
                    recs[nrec[0]] = mk_rec(KIND_BAD, '0, '0, start_eff,
                                           pos_w - start_eff + 1'b1);
                    nrec = nrec + 2'd1;
                end
            end else begin
                unique case (r_phase)
                    PH_CODE: begin
                        if (i_data_byte == PAD_CODE) begin
                            if (r_pad_cnt == '0)
                                n_pad_start = r_pos;
                            if (r_pad_cnt != SAT12)
                                n_pad_cnt = r_pad_cnt + 1'b1;
                            if (i_last_byte) begin
                                recs[nrec[0]] = mk_rec(KIND_PAD, '0, '0,
                                                       WIDE_W'(n_pad_start),
                                                       WIDE_W'(n_pad_cnt));
                                nrec = nrec + 2'd1;
                            end
                        end else begin
                            if (r_pad_cnt != '0) begin
                                recs[nrec[0]] = mk_rec(KIND_PAD, '0, '0,
                                                       WIDE_W'(r_pad_start),
                                                       WIDE_W'(r_pad_cnt));
                                nrec = nrec + 2'd1;
                                n_pad_cnt   = '0;
                                n_pad_start = '0;
                            end
                            if (i_data_byte == END_CODE) begin
                                recs[nrec[0]] = mk_rec(KIND_END, '0, '0, pos_w,
                                                       WIDE_W'(1));
                                nrec = nrec + 2'd1;
                            end else begin
                                n_held  = i_data_byte;
                                n_start = r_pos;
                                n_phase = PH_LEN;
                                if (i_last_byte) begin
                                    recs[nrec[0]] = mk_rec(KIND_BAD, '0, '0, pos_w,
                                                           WIDE_W'(1));
                                    nrec = nrec + 2'd1;
                                end
                            end
                        end
                    end
                    PH_LEN: begin
                        if (i_data_byte == 8'd0) begin
                            recs[0] = mk_rec(KIND_OPT, '0, r_held, start_w,
                                             WIDE_W'(OPT_HDR_BYTES));
                            nrec    = 2'd1;
                            n_phase = PH_CODE;
                        end else begin
                            n_left  = i_data_byte;
                            n_phase = PH_DATA;
                            if (i_last_byte) begin
                                recs[0] = mk_rec(KIND_BAD, '0, '0, start_w,
                                                 WIDE_W'(OPT_HDR_BYTES));
                                nrec    = 2'd1;
                            end
                        end
                    end
                    PH_DATA: begin
                        left_dec = (r_left != '0) ? r_left - 1'b1 : r_left;
                        n_left   = left_dec;
                        if (left_dec == '0) begin
                            recs[0] = mk_rec(KIND_OPT, '0, r_held, start_w,
                                             pos_w - start_w + 1'b1);
                            nrec    = 2'd1;
                            n_phase = PH_CODE;
                        end else if (i_last_byte) begin
                            recs[0] = mk_rec(KIND_BAD, '0, '0, start_w,
                                             pos_w - start_w + 1'b1);
                            nrec    = 2'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_CODE;
                    end
                endcase
            end
        end

        // the last byte of a packet returns everything to its reset state
        if (i_last_byte) begin
            n_hf        = '0;
            n_pos       = '0;
            n_start     = '0;
            n_left      = '0;
            n_phase     = PH_CODE;
            n_held      = '0;
            n_pad_start = '0;
            n_pad_cnt   = '0;
            n_ovf       = 1'b0;
        end
    end

    always_comb begin
        o_push.push     = accept && (nrec != 2'd0);
        o_push.entry.two = (nrec == 2'd2);
        o_push.entry.r0 = recs[0];
        o_push.entry.r1 = recs[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hf        <= '0;
            r_pos       <= '0;
            r_start     <= '0;
            r_left      <= '0;
            r_phase     <= PH_CODE;
            r_held      <= '0;
            r_pad_start <= '0;
            r_pad_cnt   <= '0;
            r_ovf       <= 1'b0;
        end else if (accept) begin
            r_hf        <= n_hf;
            r_pos       <= n_pos;
            r_start     <= n_start;
            r_left      <= n_left;
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_pad_start <= n_pad_start;
            r_pad_cnt   <= n_pad_cnt;
            r_ovf       <= n_ovf;
        end
    end

endmodule

FILE: rtl/dps_queue.sv
// Short queue of per-byte result entries between front and back end.
// Uses dps_pkg for the entry type and depth.
module dps_queue import dps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_qstat  o_qstat
);

    t_entry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QPTR_W:0]    r_cnt;
    logic               do_pop;

    assign o_qstat.full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.push)
            r_mem[r_wr] <= i_push.entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push)
                r_wr <= r_wr + 1'b1;
            if (do_pop)
                r_rd <= r_rd + 1'b1;
            if (i_push.push && !do_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push.push && do_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: rtl/dps_back.sv
// Back end: walks the head queue entry one record per handshake and
// marks the last record of each byte. Uses dps_pkg.
module dps_back import dps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rec        o_rec,
    output logic        o_last_of_run
);

    logic r_sel;

    assign o_valid       = !i_qstat.empty;
    assign o_rec         = r_sel ? i_head.r1 : i_head.r0;
    assign o_last_of_run = r_sel || !i_head.two;
    assign o_pop         = o_valid && i_ready && o_last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_sel <= !o_last_of_run;
        end
    end

endmodule

FILE: rtl/dhcp_packet_segmenter.sv
// Top level of the DHCPv4 packet segmenter: front parser, result queue, back end.
// Depends on dps_pkg, dps_front, dps_queue, dps_back and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  byte in | input     | i_valid / o_ready  | i_data_byte, i_last_byte
//  segment | output    | o_valid / i_ready  | o_seg_kind, o_field_index, o_option_code,
//          |           |                    | o_seg_offset, o_seg_length, o_last_of_run
//
// One byte is accepted per cycle; its records enter the 4-entry queue on the same edge.
// Each record takes its own output handshake, so a byte with two records shows them in turn.
// Input stalls only when the queue is full; the output shows the queue head directly.
// Reset is synchronous and active low; no clearing pass.
`include "assert_macros.svh"

module dhcp_packet_segmenter import dps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_seg_kind,
    output logic [3:0]  o_field_index,
    output logic [7:0]  o_option_code,
    output logic [11:0] o_seg_offset,
    output logic [11:0] o_seg_length,
    output logic        o_last_of_run
);

    t_push  push;
    t_qstat qstat;
    t_entry head;
    t_rec   rec;
    logic   pop;

    dps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_qstat     (qstat),
        .o_push      (push)
    );

    dps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    dps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_rec         (rec),
        .o_last_of_run (o_last_of_run)
    );

    assign o_seg_kind    = rec.kind;
    assign o_field_index = rec.field_index;
    assign o_option_code = rec.option_code;
    assign o_seg_offset  = rec.offset;
    assign o_seg_length  = rec.length;

    `ASSERT_NEXT(a_pair_second, i_clk, i_rst_n, o_valid && i_ready && !o_last_of_run, o_valid && o_last_of_run, "second record of a byte missing")
    `ASSERT_IMPLY(a_end_len, i_clk, i_rst_n, o_valid && o_seg_kind == KIND_END, o_seg_length == 12'd1, "end option length not one")
    `ASSERT_IMPLY(a_code_zero, i_clk, i_rst_n, o_valid && o_seg_kind != KIND_OPT, o_option_code == 8'd0, "option code on non-option segment")
    `ASSERT_IMPLY(a_fidx_zero, i_clk, i_rst_n, o_valid && o_seg_kind != KIND_HDR, o_field_index == 4'd0, "field index on non-header segment")

endmodule

FILE: tb/dhcp_packet_segmenter_tb.sv
`timescale 1ns / 100ps
// Testbench for dhcp_packet_segmenter: feeds DHCPv4 packets byte by byte and checks every
// reported segment against a cycle-free model of the segmenter held in this file.
// Depends on dps_pkg and the RTL of the block.
module dhcp_packet_segmenter_tb;
    import dps_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SHOW_MAX    = 10;
    localparam int FIELD_BYTES [0:14] = '{1, 1, 1, 1, 4, 2, 2, 4, 4, 4, 4,
                                          CHADDR_BYTES, SNAME_BYTES, FILE_BYTES, 4};

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  field_index;
        logic [7:0]  option_code;
        logic [11:0] offset;
        logic [11:0] length;
        logic        last_of_run;
    } t_seg;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_seg_kind;
    logic [3:0]  o_field_index;
    logic [7:0]  o_option_code;
    logic [11:0] o_seg_offset;
    logic [11:0] o_seg_length;
    logic        o_last_of_run;

    dhcp_packet_segmenter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_seg_kind    (o_seg_kind),
        .o_field_index (o_field_index),
        .o_option_code (o_option_code),
        .o_seg_offset  (o_seg_offset),
        .o_seg_length  (o_seg_length),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // segmenter model state
    logic [3:0]  hdr_idx;      // 15 once the header is done
    logic [12:0] pos;
    logic [11:0] start_off;
    logic [7:0]  left;
    t_phase      opt_state;
    logic [7:0]  code_held;
    logic [11:0] pad_off;
    logic [11:0] pad_len;
    logic        past_cap;

    t_seg        found[$];     // segments caused by the current byte
    t_seg        segs_due[$];
    logic [7:0]  pkt_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int segs_checked   = 0;
    int bytes_sent     = 0;
    int packets_sent   = 0;
    int overrun_pkts   = 0;
    int quiet_cycles   = 0;

    function automatic logic [11:0] clamp12(input int v);
        return (v > int'(SAT12)) ? SAT12 : 12'(v);
    endfunction

    task automatic add_seg(input t_kind kind, input logic [3:0] fidx, input logic [7:0] code,
                           input int off, input int len);
        t_seg s;
        s.kind        = kind;
        s.field_index = fidx;
        s.option_code = code;
        s.offset      = clamp12(off);
        s.length      = clamp12(len);
        s.last_of_run = 1'b0;
        found.push_back(s);
    endtask

    task automatic flush_pads();
        if (pad_len != 0) begin
            add_seg(KIND_PAD, 4'd0, 8'd0, pad_off, pad_len);
            pad_len = '0;
            pad_off = '0;
        end
    endtask

    task automatic clear_parser();
        hdr_idx   = '0;
        pos       = '0;
        start_off = '0;
        left      = '0;
        opt_state = PH_CODE;
        code_held = '0;
        pad_off   = '0;
        pad_len   = '0;
        past_cap  = 1'b0;
    endtask

    // advance the model by one accepted byte and queue the segments it closes
    task automatic segment_byte(input logic [7:0] b, input logic is_last);
        found.delete();
        if (past_cap) begin
            if (is_last) clear_parser();
        end else if (pos >= MAX_PACKET_BYTES) begin
            if (hdr_idx < HDR_FIELDS) begin
                if (left != 0) add_seg(KIND_BAD, 4'd0, 8'd0, start_off, int'(pos) - start_off);
                else add_seg(KIND_BAD, 4'd0, 8'd0, pos, 0);
            end else if (opt_state == PH_CODE) begin
                flush_pads();
                add_seg(KIND_BAD, 4'd0, 8'd0, pos, 0);
            end else begin
                add_seg(KIND_BAD, 4'd0, 8'd0, start_off, int'(pos) - start_off);
            end
            past_cap = 1'b1;
            if (is_last) clear_parser();
        end else begin
            if (hdr_idx < HDR_FIELDS) begin
                if (left == 0) begin
                    start_off = pos[11:0];
                    left      = 8'(FIELD_BYTES[hdr_idx]);
                end
                left = left - 8'd1;
                if (left == 0) begin
                    add_seg(KIND_HDR, hdr_idx, 8'd0, start_off, FIELD_BYTES[hdr_idx]);
                    hdr_idx = hdr_idx + 4'd1;
                    // cut at a field boundary: empty remainder at the next offset
                    if (is_last && hdr_idx < HDR_FIELDS)
                        add_seg(KIND_BAD, 4'd0, 8'd0, int'(pos) + 1, 0);
                end else if (is_last) begin
                    add_seg(KIND_BAD, 4'd0, 8'd0, start_off, int'(pos) - start_off + 1);
                end
            end else if (opt_state == PH_CODE) begin
                if (b == PAD_CODE) begin
                    if (pad_len == 0) pad_off = pos[11:0];
                    if (pad_len < SAT12) pad_len = pad_len + 12'd1;
                    if (is_last) flush_pads();
                end else begin
                    flush_pads();
                    if (b == END_CODE) begin
                        add_seg(KIND_END, 4'd0, 8'd0, pos, 1);
                    end else begin
                        code_held = b;
                        start_off = pos[11:0];
                        opt_state = PH_LEN;
                        if (is_last) add_seg(KIND_BAD, 4'd0, 8'd0, start_off, 1);
                    end
                end
            end else if (opt_state == PH_LEN) begin
                if (b == 8'd0) begin
                    add_seg(KIND_OPT, 4'd0, code_held, start_off, OPT_HDR_BYTES);
                    opt_state = PH_CODE;
                end else begin
                    left      = b;
                    opt_state = PH_DATA;
                    if (is_last) add_seg(KIND_BAD, 4'd0, 8'd0, start_off, OPT_HDR_BYTES);
                end
            end else begin
                if (left != 0) left = left - 8'd1;
                if (left == 0) begin
                    add_seg(KIND_OPT, 4'd0, code_held, start_off, int'(pos) - start_off + 1);
                    opt_state = PH_CODE;
                end else if (is_last) begin
                    add_seg(KIND_BAD, 4'd0, 8'd0, start_off, int'(pos) - start_off + 1);
                end
            end
            pos = pos + 13'd1;
            if (is_last) clear_parser();
        end
        foreach (found[k]) begin
            if (k == found.size() - 1) found[k].last_of_run = 1'b1;
            segs_due.push_back(found[k]);
        end
    endtask

    // one byte: optional idle gap, then hold valid until accepted
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        segment_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[k]) send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1);
        packets_sent++;
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (segs_due.size() != 0);
    endtask

    task automatic add_header();
        repeat (240) pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_pads(input int n);
        repeat (n) pkt_bytes.push_back(PAD_CODE);
    endtask

    task automatic add_option(input logic [7:0] code, input logic [7:0] len);
        pkt_bytes.push_back(code);
        pkt_bytes.push_back(len);
        repeat (len) pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    // packets cut short inside the header, both mid-field and at field boundaries
    task automatic test_header_cuts();
        pkt_bytes = '{8'hFF};
        send_packet();
        pkt_bytes = '{8'h00, 8'hFF, 8'h00, 8'h80};
        send_packet();
        pkt_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'hFF};
        send_packet();
        pkt_bytes = '{8'h00, 8'h01, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
        send_packet();
    endtask

    task automatic test_option_cases();
        // pad runs, end, empty option, longest option, pads flushed at packet end
        pkt_bytes.delete();
        add_header();
        add_pads(3);
        pkt_bytes.push_back(END_CODE);
        add_option(8'd1, 8'd0);
        add_option(8'd254, 8'd255);
        add_pads(2);
        add_option(8'h35, 8'd1);
        pkt_bytes.push_back(END_CODE);
        add_pads(1);
        send_packet();
        // ends right after the cookie
        pkt_bytes.delete();
        add_header();
        send_packet();
        // pads then a lone code byte
        pkt_bytes.delete();
        add_header();
        add_pads(2);
        pkt_bytes.push_back(8'h63);
        send_packet();
        // cut on the length byte
        pkt_bytes.delete();
        add_header();
        pkt_bytes.push_back(8'h01);
        pkt_bytes.push_back(8'h08);
        send_packet();
        // cut inside option data
        pkt_bytes.delete();
        add_header();
        pkt_bytes.push_back(8'h03);
        pkt_bytes.push_back(8'h04);
        pkt_bytes.push_back(8'hC0);
        pkt_bytes.push_back(8'h3F);
        send_packet();
    endtask

    task automatic test_capacity_overrun();
        int r;
        // overrun during a pad run, a few ignored bytes after it
        pkt_bytes.delete();
        add_header();
        add_pads(MAX_PACKET_BYTES - 240);
        repeat (3) pkt_bytes.push_back(8'($urandom_range(255)));
        send_packet();
        overrun_pkts++;
        // overrun on an option's length byte, last flag on the overrun byte
        pkt_bytes.delete();
        add_header();
        while (pkt_bytes.size() <= MAX_PACKET_BYTES)
            add_option(8'($urandom_range(1, 254)), 8'd255);
        pkt_bytes = pkt_bytes[0:MAX_PACKET_BYTES];
        send_packet();
        overrun_pkts++;
        // options end exactly at capacity, overrun with no segment open
        pkt_bytes.delete();
        add_header();
        while (MAX_PACKET_BYTES - pkt_bytes.size() > 257)
            add_option(8'($urandom_range(1, 254)), 8'd255);
        r = MAX_PACKET_BYTES - pkt_bytes.size();
        if (r >= 2) add_option(8'($urandom_range(1, 254)), 8'(r - 2));
        else if (r == 1) pkt_bytes.push_back(END_CODE);
        repeat (3) pkt_bytes.push_back(8'($urandom_range(255)));
        send_packet();
        overrun_pkts++;
    endtask

    task automatic test_random_packets(input int idle_pct, input int stall_pct,
                                       input int n_bytes);
        int stop_at;
        int pick;
        int acc;
        int k;
        int cut;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pkt_bytes.delete();
            pick = $urandom_range(99);
            if (pick < 35) begin
                add_header();
                if ($urandom_range(1)) begin
                    acc = 0;
                    k = $urandom_range(14);
                    for (int j = 0; j <= k; j++) acc += FIELD_BYTES[j];
                end else begin
                    acc = $urandom_range(1, 239);
                end
                pkt_bytes = pkt_bytes[0:acc-1];
            end else if (pick < 85) begin
                add_header();
                repeat ($urandom_range(6)) begin
                    k = $urandom_range(9);
                    if (k < 3) add_pads($urandom_range(1, 4));
                    else if (k == 3) pkt_bytes.push_back(END_CODE);
                    else if ($urandom_range(9) == 0)
                        add_option(8'($urandom_range(1, 254)), 8'($urandom_range(255)));
                    else
                        add_option(8'($urandom_range(1, 254)), 8'($urandom_range(12)));
                end
                if ($urandom_range(1)) pkt_bytes.push_back(END_CODE);
                if ($urandom_range(9) < 3 && pkt_bytes.size() > 241) begin
                    cut = $urandom_range(241, pkt_bytes.size() - 1);
                    pkt_bytes = pkt_bytes[0:cut-1];
                end
            end else begin
                repeat ($urandom_range(1, 320)) pkt_bytes.push_back(8'($urandom_range(255)));
            end
            send_packet();
        end
    endtask

    task automatic note_mismatch(input t_seg want, input t_seg got);
        fail_count++;
        if (fail_count <= SHOW_MAX) begin
            $display("segment %0d mismatch at %0t", segs_checked, $realtime);
            $display("  expected kind %0d field %0d code %0d off %0d len %0d last %0b",
                     want.kind, want.field_index, want.option_code, want.offset,
                     want.length, want.last_of_run);
            $display("  actual   kind %0d field %0d code %0d off %0d len %0d last %0b",
                     got.kind, got.field_index, got.option_code, got.offset,
                     got.length, got.last_of_run);
        end
    endtask

    always @(posedge i_clk) begin : check_segments
        t_seg got;
        t_seg want;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind        = t_kind'(o_seg_kind);
            got.field_index = o_field_index;
            got.option_code = o_option_code;
            got.offset      = o_seg_offset;
            got.length      = o_seg_length;
            got.last_of_run = o_last_of_run;
            if (segs_due.size() == 0) begin
                want = '0;
                note_mismatch(want, got);
                if (fail_count <= SHOW_MAX) $display("  (no segment was expected)");
            end else begin
                want = segs_due.pop_front();
                if (got !== want) note_mismatch(want, got);
            end
            segs_checked++;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d segments outstanding",
                     quiet_cycles, segs_due.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'd0;
        i_last_byte <= 1'b0;
        i_ready     <= 1'b0;
        clear_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_cuts();
        test_option_cases();
        hold_until_drained();
        test_capacity_overrun();
        test_random_packets(0, 0, 500);
        test_random_packets(80, 0, 500);
        hold_until_drained();
        test_random_packets(0, 80, 500);
        test_random_packets(35, 35, 500);

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (segs_due.size() != 0) begin
            fail_count++;
            $display("%0d expected segments never arrived", segs_due.size());
        end
        $display("Ran %0d packets (%0d over capacity), %0d bytes, %0d segments checked,",
                 packets_sent, overrun_pkts, bytes_sent, segs_checked);
        $display("with header cuts, option cuts, pad runs and sender/receiver stalls; %0d errors",
                 fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
